// ----- hdl/bab_pkg.sv -----
// Shared types and constants for the box average binning block.
// No dependencies; every other file in hdl but bab_serdiv refers to this package.
package bab_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int SUM_W         = 40;
  localparam int FACT_W        = 5;
  localparam int SIZE_W        = 13;
  localparam int POS_W         = 12;
  localparam int DEN_W         = 2 * FACT_W;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = SIZE_W;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_BIN       = 16;
  localparam int MAX_HEIGHT    = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_X        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_Y        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd3;

  typedef struct packed {
    logic accept;
    logic eval;
    logic acc;
    logic div_start;
    logic out_load;
    logic fix_start;
    logic fix_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic dirty;
    logic in_block;
    logic end_x;
    logic end_y;
    logic avg_busy;
    logic fix_busy;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hdl/box_average_binning.sv -----
// Top level of the box average binning block: controller plus datapath.
// Uses bab_pkg, bab_ctrl, bab_datapath.
//
// Samples of a slice arrive in raster order; each bin_x by bin_y block is
// summed exactly in 40 bits and divided once by bin_x*bin_y, truncating toward
// zero, then emitted with its block column and row. Columns and rows beyond
// whole blocks produce nothing. One transaction is in work at a time: a sample
// that does not close a block row only passes the evaluate state, one that
// closes a block row also updates the column sum memory, and one that closes a
// block then waits on the 40-step serial divider behind the column sum memory.
// The result sits in an output register, so the next sample is taken while it
// waits. A write of bin_x or bin_y makes the block re-split the current
// position by serial division, stalling input until the split is done.
// Configuration is taken only while no transaction is in work.
module box_average_binning #(
  parameter int MAX_WIDTH = bab_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bab_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bab_pkg::SAMPLE_W-1:0] out_binned_sample,
  output logic [bab_pkg::POS_W-1:0]           out_bin_column,
  output logic [bab_pkg::POS_W-1:0]           out_bin_row,
  output logic                                out_last_of_frame,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bab_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bab_pkg::ctrl_cmd_t cmd;
  bab_pkg::dp_sts_t   sts;
  logic               cfg_we;

  assign cfg_we = cfg_valid & cfg_ready;

  bab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  bab_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sample         (in_sample),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_binned_sample (out_binned_sample),
    .out_bin_column    (out_bin_column),
    .out_bin_row       (out_bin_row),
    .out_last_of_frame (out_last_of_frame)
  );

`ifndef SYNTHESIS
  ap_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  ap_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> cfg_ready)
    else $error("input accepted while a transaction is in work");

  ap_bin_resplit: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == bab_pkg::CFG_BIN_X || cfg_index == bab_pkg::CFG_BIN_Y))
    |=> in_stall)
    else $error("binning change did not hold input for position re-split");

  ap_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in work");
`endif

endmodule

// ----- hdl/bab_serdiv.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Unsigned operands; depends on nothing else.
module bab_serdiv #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o,
  output logic             busy_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem_r, num_r[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = (shifted >= {1'b0, den_r});

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (start_i) begin
      num_nxt = num_i;
      rem_nxt = '0;
      den_nxt = den_i;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      num_nxt = {num_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo_o  = num_r;
  assign rem_o  = rem_r;
  assign busy_o = (cnt_r != '0);

endmodule

// ----- hdl/bab_datapath.sv -----
// Datapath: configuration registers, position counters, column sum memory,
// row sum, block average divider and output register. Uses bab_pkg, bab_serdiv.
module bab_datapath #(
  parameter int MAX_WIDTH = bab_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bab_pkg::ctrl_cmd_t                cmd,
  output bab_pkg::dp_sts_t                  sts,
  input  logic                              cfg_we,
  input  logic [bab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bab_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [bab_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [bab_pkg::SAMPLE_W-1:0] out_binned_sample,
  output logic [bab_pkg::POS_W-1:0]         out_bin_column,
  output logic [bab_pkg::POS_W-1:0]         out_bin_row,
  output logic                              out_last_of_frame
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int CW   = (XW + 2 > bab_pkg::SIZE_W + 1) ? XW + 2 : bab_pkg::SIZE_W + 1;
  localparam int HW   = bab_pkg::SIZE_W + 2;
  localparam int FW   = bab_pkg::FACT_W;
  localparam int PW   = bab_pkg::POS_W;
  localparam int SW   = bab_pkg::SUM_W;
  localparam int DW   = bab_pkg::SAMPLE_W;
  localparam int NW   = bab_pkg::DEN_W;

  // configuration
  logic [FW-1:0]                  bin_x_r, bin_y_r;
  logic [bab_pkg::SIZE_W-1:0]     line_width_r, frame_height_r;
  logic                           dirty_r, dirty_nxt;
  logic [FW-1:0]                  bx_f, by_f;
  logic [CW-1:0]                  width_f, lw_ext;
  logic [HW-1:0]                  height_f, fh_ext;

  // position counters
  logic [XW-1:0] x_r, x_nxt, bcol_r, bcol_nxt;
  logic [PW-1:0] y_r, y_nxt, brow_r, brow_nxt;
  logic [FW-1:0] ix_r, ix_nxt, iy_r, iy_nxt;
  logic [CW-1:0] x_inc;
  logic [HW-1:0] y_inc;
  logic          x_wrap, y_wrap, ix_end, iy_end;

  // transaction held for evaluation
  logic signed [DW-1:0] sample_q;
  logic [XW-1:0]        x_q, bcol_q;
  logic [PW-1:0]        y_q, brow_q;
  logic [FW-1:0]        ix_q, iy_q;
  logic [CW-1:0]        xb;
  logic [HW-1:0]        yb;
  logic                 inx, iny, lastx, lasty, last, first_x, first_y;

  // sums
  logic [SW-1:0] rps_r, rps_nxt, sx, rd_r, colsum, colsum_r, avg_num;
  logic [SW-1:0] col_mem [MAX_WIDTH];
  logic          neg_r;

  // dividers
  logic [SW-1:0] avg_quo;
  logic [NW-1:0] avg_den;
  logic          avg_busy;
  logic [XW-1:0] fx_quo;
  logic [FW-1:0] fx_rem;
  logic          fx_busy;
  logic [PW-1:0] fy_quo;
  logic [FW-1:0] fy_rem;
  logic          fy_busy;

  // output register
  logic                 out_valid_r;
  logic signed [DW-1:0] binned_r;
  logic [PW-1:0]        ocol_r, orow_r;
  logic                 olast_r;
  logic                 out_free;

  // effective configuration
  always_comb begin
    if (bin_x_r == '0) begin
      bx_f = FW'(1);
    end else if (int'(bin_x_r) > bab_pkg::MAX_BIN) begin
      bx_f = FW'(bab_pkg::MAX_BIN);
    end else begin
      bx_f = bin_x_r;
    end
    if (bin_y_r == '0) begin
      by_f = FW'(1);
    end else if (int'(bin_y_r) > bab_pkg::MAX_BIN) begin
      by_f = FW'(bab_pkg::MAX_BIN);
    end else begin
      by_f = bin_y_r;
    end
    lw_ext = CW'(line_width_r);
    if (lw_ext == '0) begin
      width_f = CW'(1);
    end else if (lw_ext > CW'(MAX_WIDTH)) begin
      width_f = CW'(MAX_WIDTH);
    end else begin
      width_f = lw_ext;
    end
    fh_ext = HW'(frame_height_r);
    if (fh_ext == '0) begin
      height_f = HW'(1);
    end else if (fh_ext > HW'(bab_pkg::MAX_HEIGHT)) begin
      height_f = HW'(bab_pkg::MAX_HEIGHT);
    end else begin
      height_f = fh_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_x_r        <= FW'(1);
      bin_y_r        <= FW'(1);
      line_width_r   <= bab_pkg::SIZE_W'(4096);
      frame_height_r <= bab_pkg::SIZE_W'(4096);
    end else if (cfg_we) begin
      case (cfg_index)
        bab_pkg::CFG_BIN_X:        bin_x_r        <= cfg_data[FW-1:0];
        bab_pkg::CFG_BIN_Y:        bin_y_r        <= cfg_data[FW-1:0];
        bab_pkg::CFG_LINE_WIDTH:   line_width_r   <= cfg_data;
        bab_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dirty_nxt = dirty_r;
    if (cmd.fix_commit) begin
      dirty_nxt = 1'b0;
    end
    if (cfg_we && (cfg_index == bab_pkg::CFG_BIN_X || cfg_index == bab_pkg::CFG_BIN_Y)) begin
      dirty_nxt = 1'b1;
    end
  end

  // advance position
  assign x_inc  = CW'(x_r) + CW'(1);
  assign y_inc  = HW'(y_r) + HW'(1);
  assign x_wrap = (x_inc >= width_f);
  assign y_wrap = (y_inc >= height_f);
  assign ix_end = (ix_r == bx_f - FW'(1));
  assign iy_end = (iy_r == by_f - FW'(1));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    ix_nxt   = ix_r;
    iy_nxt   = iy_r;
    bcol_nxt = bcol_r;
    brow_nxt = brow_r;
    if (cmd.accept) begin
      if (x_wrap) begin
        x_nxt    = '0;
        ix_nxt   = '0;
        bcol_nxt = '0;
        if (y_wrap) begin
          y_nxt    = '0;
          iy_nxt   = '0;
          brow_nxt = '0;
        end else begin
          y_nxt = PW'(y_inc);
          if (iy_end) begin
            iy_nxt   = '0;
            brow_nxt = brow_r + PW'(1);
          end else begin
            iy_nxt = iy_r + FW'(1);
          end
        end
      end else begin
        x_nxt = XW'(x_inc);
        if (ix_end) begin
          ix_nxt   = '0;
          bcol_nxt = bcol_r + XW'(1);
        end else begin
          ix_nxt = ix_r + FW'(1);
        end
      end
    end else if (cmd.fix_commit) begin
      ix_nxt   = fx_rem;
      bcol_nxt = fx_quo;
      iy_nxt   = fy_rem;
      brow_nxt = fy_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r     <= '0;
      y_r     <= '0;
      ix_r    <= '0;
      iy_r    <= '0;
      bcol_r  <= '0;
      brow_r  <= '0;
      dirty_r <= 1'b0;
      rps_r   <= '0;
    end else begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      ix_r    <= ix_nxt;
      iy_r    <= iy_nxt;
      bcol_r  <= bcol_nxt;
      brow_r  <= brow_nxt;
      dirty_r <= dirty_nxt;
      rps_r   <= rps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= in_sample;
      x_q      <= x_r;
      y_q      <= y_r;
      ix_q     <= ix_r;
      iy_q     <= iy_r;
      bcol_q   <= bcol_r;
      brow_q   <= brow_r;
    end
  end

  // block membership of the held transaction
  assign xb      = CW'(x_q) - CW'(ix_q);
  assign yb      = HW'(y_q) - HW'(iy_q);
  assign inx     = (xb + CW'(bx_f) <= width_f);
  assign iny     = (yb + HW'(by_f) <= height_f);
  assign lastx   = (xb + CW'({bx_f, 1'b0}) > width_f);
  assign lasty   = (yb + HW'({by_f, 1'b0}) > height_f);
  assign last    = lastx & lasty;
  assign first_x = (ix_q == '0);
  assign first_y = (iy_q == '0);

  // row and column sums
  assign sx = {{(SW - DW){sample_q[DW-1]}}, sample_q};

  always_comb begin
    rps_nxt = rps_r;
    if (cmd.eval && inx && iny) begin
      rps_nxt = first_x ? sx : rps_r + sx;
    end
  end

  assign colsum = first_y ? rps_r : rd_r + rps_r;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      col_mem[bcol_q] <= colsum;
    end
    rd_r <= col_mem[bcol_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      colsum_r <= colsum;
    end
    if (cmd.div_start) begin
      neg_r <= colsum_r[SW-1];
    end
  end

  // block average
  assign avg_num = colsum_r[SW-1] ? -colsum_r : colsum_r;
  assign avg_den = NW'(bx_f) * NW'(by_f);

  bab_serdiv #(
    .NUM_W (SW),
    .DEN_W (NW)
  ) u_avg_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd.div_start),
    .num_i   (avg_num),
    .den_i   (avg_den),
    .quo_o   (avg_quo),
    .rem_o   (),
    .busy_o  (avg_busy)
  );

  // position split after a binning change
  bab_serdiv #(
    .NUM_W (XW),
    .DEN_W (FW)
  ) u_fix_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd.fix_start),
    .num_i   (x_r),
    .den_i   (bx_f),
    .quo_o   (fx_quo),
    .rem_o   (fx_rem),
    .busy_o  (fx_busy)
  );

  bab_serdiv #(
    .NUM_W (PW),
    .DEN_W (FW)
  ) u_fix_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd.fix_start),
    .num_i   (y_r),
    .den_i   (by_f),
    .quo_o   (fy_quo),
    .rem_o   (fy_rem),
    .busy_o  (fy_busy)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      binned_r <= neg_r ? -avg_quo[DW-1:0] : avg_quo[DW-1:0];
      ocol_r   <= PW'(bcol_q);
      orow_r   <= brow_q;
      olast_r  <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_binned_sample = binned_r;
  assign out_bin_column    = ocol_r;
  assign out_bin_row       = orow_r;
  assign out_last_of_frame = olast_r;

  assign sts.dirty    = dirty_r;
  assign sts.in_block = inx & iny;
  assign sts.end_x    = (ix_q == bx_f - FW'(1));
  assign sts.end_y    = (iy_q == by_f - FW'(1));
  assign sts.avg_busy = avg_busy;
  assign sts.fix_busy = fx_busy | fy_busy;
  assign sts.out_free = out_free;

endmodule

// ----- hdl/bab_ctrl.sv -----
// Controller state machine for the box average binning block.
// Drives datapath commands from its status; uses bab_pkg.
module bab_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bab_pkg::dp_sts_t   sts,
  output bab_pkg::ctrl_cmd_t cmd,
  output logic               in_stall,
  output logic               cfg_ready
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_EVAL  = 8'b0000_0010,
    ST_ACC   = 8'b0000_0100,
    ST_DIVGO = 8'b0000_1000,
    ST_DIVW  = 8'b0001_0000,
    ST_OUT   = 8'b0010_0000,
    ST_FIXGO = 8'b0100_0000,
    ST_FIXW  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (sts.dirty) begin
          state_nxt = ST_FIXGO;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = (sts.in_block && sts.end_x) ? ST_ACC : ST_IDLE;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.end_y ? ST_DIVGO : ST_IDLE;
      end
      ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (!sts.avg_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FIXGO: begin
        cmd.fix_start = 1'b1;
        state_nxt     = ST_FIXW;
      end
      ST_FIXW: begin
        if (!sts.fix_busy) begin
          cmd.fix_commit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = !((state_r == ST_IDLE) && !sts.dirty);
  assign cfg_ready = (state_r == ST_IDLE);

endmodule
